// File: rtl/rpn_pkg.sv
// Package for the postfix stack evaluator: token codes, register indexes
// and the sequencer state type. No dependencies.
package rpn_pkg;
   localparam int DataWidth = 32;
   localparam logic [31:0] ErrorValue = 32'h8000_0000;

   typedef enum logic [5:0] {
      TOK_END = 6'd0, TOK_IMM8 = 6'd1, TOK_IMM16 = 6'd2, TOK_PC = 6'd3,
      TOK_A = 6'd4, TOK_X = 6'd5, TOK_Y = 6'd6, TOK_S = 6'd7,
      TOK_FC = 6'd8, TOK_FZ = 6'd9, TOK_FI = 6'd10, TOK_FD = 6'd11,
      TOK_FV = 6'd12, TOK_FN = 6'd13,
      TOK_EQ = 6'd16, TOK_LT = 6'd17, TOK_GT = 6'd18, TOK_LE = 6'd19,
      TOK_GE = 6'd20, TOK_LAND = 6'd21, TOK_LOR = 6'd22,
      TOK_ADD = 6'd29, TOK_SUB = 6'd30, TOK_MUL = 6'd31, TOK_DIV = 6'd32,
      TOK_AND = 6'd33, TOK_OR = 6'd34, TOK_XOR = 6'd35, TOK_SHL = 6'd36,
      TOK_SHR = 6'd37, TOK_LNOT = 6'd38, TOK_NEG = 6'd39
   } token_type;

   localparam logic [2:0] RegPc = 3'd0, RegA = 3'd1, RegX = 3'd2, RegY = 3'd3,
                          RegS = 3'd4, RegP = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_LOAD, ST_SERIAL, ST_WRITE, ST_RESP
   } state_type;
endpackage

// File: rtl/rpn_stack_evaluator.sv
// Top level of the postfix stack evaluator: token decode, value stack
// memory and a bit-serial arithmetic unit. Depends on rpn_pkg.
//
// Usage: tokens arrive as transactions on req_ (req_func, req_operand).
// Value tokens push a constant, a register snapshot or a status flag; operator
// tokens pop one or two values and push the result. Only the end token gives
// a transaction on rsp_: the single stack value with rsp_failed low, or
// 0x80000000 with rsp_failed high after any error or a final depth other than
// one. The end token also empties the stack. The user must write register
// snapshots through csr_ only while the block is idle; the block itself
// does not enforce this. csr_ready is always high.
// Timing: one token at a time. A push is written in the read state, and a
// token that is ignored after an error is taken without leaving idle.
// Operators read their operands from the single-port stack memory in the
// load state, then the arithmetic unit runs bit-serially: 32 steps for add,
// subtract, logic and compare work, 33 for shifts, 32 shift-add steps for
// multiply and 32 restore steps for divide plus a magnitude and a sign fix
// step, each followed by a finish step and the write state. The end token
// waits for rsp_ready; while the receiver stalls the result is held and no
// token is accepted.
// Reset (synchronous, active high) empties the stack, clears the error flag
// and the snapshot registers; stack contents are not cleared.
module rpn_stack_evaluator #(
   parameter int STACK_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [5:0]  req_func,
   input  logic [15:0] req_operand,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_result_value,
   output logic        rsp_failed,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import rpn_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam logic [DW-1:0] Full = DW'(STACK_DEPTH);

   // Snapshot registers.
   logic [15:0] pc_ff;
   logic [7:0]  a_ff, x_ff, y_ff, s_ff, p_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0; a_ff <= '0; x_ff <= '0; y_ff <= '0; s_ff <= '0; p_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            RegPc: pc_ff <= csr_data;
            RegA:  a_ff <= csr_data[7:0];
            RegX:  x_ff <= csr_data[7:0];
            RegY:  y_ff <= csr_data[7:0];
            RegS:  s_ff <= csr_data[7:0];
            RegP:  p_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Stack memory, one port, registered read.
   logic [31:0] mem [STACK_DEPTH];
   logic [31:0] rd_ff;
   logic        mem_we;
   logic [AW-1:0] mem_addr;
   logic [31:0] mem_wd;
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wd;
      rd_ff <= mem[mem_addr];
   end

   state_type state_ff, state_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic          err_ff, err_in;
   logic [5:0]    func_ff;
   logic [15:0]   opnd_ff;
   logic          rd_cnt_ff;    // which operand the memory is delivering
   logic [31:0]   l_ff, r_ff;   // left / right operand shift registers
   logic [31:0]   acc_ff;       // result or remainder shift register
   logic [31:0]   q_ff;         // quotient / product shift register
   logic [6:0]    cnt_ff;
   logic          c_ff;         // carry / borrow of the serial adder
   logic          eq_ff;        // running equality of l and r
   logic          nz_ff;        // running nonzero of r
   logic          nl_ff, nr_ff;
   logic [1:0]    ph_ff;        // divide phase: 0 magnitude, 1 loop, 2 fix
   logic          fail_ff;

   wire is_bin = (func_ff >= 6'd16 && func_ff <= 6'd22) ||
                 (func_ff >= 6'd29 && func_ff <= 6'd37);
   wire is_un  = (func_ff == TOK_LNOT) || (func_ff == TOK_NEG);
   wire is_push = (func_ff >= 6'd1 && func_ff <= 6'd13);
   wire need = is_bin ? 1'b1 : 1'b0;
   wire [DW-1:0] need_n = is_bin ? DW'(2) : DW'(1);

   logic [31:0] push_val;
   always_comb begin
      unique case (func_ff)
         TOK_IMM8:  push_val = {24'd0, opnd_ff[7:0]};
         TOK_IMM16: push_val = {16'd0, opnd_ff};
         TOK_PC:    push_val = {16'd0, pc_ff};
         TOK_A:     push_val = {24'd0, a_ff};
         TOK_X:     push_val = {24'd0, x_ff};
         TOK_Y:     push_val = {24'd0, y_ff};
         TOK_S:     push_val = {24'd0, s_ff};
         TOK_FC:    push_val = {31'd0, p_ff[0]};
         TOK_FZ:    push_val = {31'd0, p_ff[1]};
         TOK_FI:    push_val = {31'd0, p_ff[2]};
         TOK_FD:    push_val = {31'd0, p_ff[3]};
         TOK_FV:    push_val = {31'd0, p_ff[6]};
         default:   push_val = {31'd0, p_ff[7]};
      endcase
   end

   // Serial full adder and subtractor on the low bits of the operand registers.
   wire sum_bit  = l_ff[0] ^ r_ff[0] ^ c_ff;
   wire sum_c    = (l_ff[0] & r_ff[0]) | (c_ff & (l_ff[0] ^ r_ff[0]));
   wire sub_bit  = l_ff[0] ^ ~r_ff[0] ^ c_ff;
   wire sub_c    = (l_ff[0] & ~r_ff[0]) | (c_ff & (l_ff[0] ^ ~r_ff[0]));
   // Running less-than built lsb first: last differing bit decides.
   logic lt_ff;
   wire [4:0] shamt = r_ff[4:0];
   wire [5:0] fn = func_ff;
   wire [32:0] dtrial = {acc_ff, q_ff[31]} - {1'b0, r_ff};

   always_comb begin
      state_in = state_ff;
      depth_in = depth_ff;
      err_in = err_ff;
      priority case (state_ff)
         ST_IDLE: if (req_valid) begin
            if (req_func == TOK_END) state_in = ST_RESP;
            else if (!err_ff) state_in = ST_READ;
         end
         ST_READ: begin
            if (is_push) begin
               if (depth_ff >= Full) err_in = 1'b1;
               else depth_in = depth_ff + DW'(1);
               state_in = ST_IDLE;
            end else if (is_bin || is_un) begin
               if (depth_ff < need_n) begin err_in = 1'b1; state_in = ST_IDLE; end
               else state_in = ST_LOAD;
            end else begin
               err_in = 1'b1; state_in = ST_IDLE;
            end
         end
         ST_LOAD: if (rd_cnt_ff == 1'b0) state_in = ST_SERIAL;
         ST_SERIAL: begin
            if (func_ff == TOK_DIV && r_ff == 32'd0 && ph_ff == 2'd0 && cnt_ff == 7'd0) begin
               err_in = 1'b1; state_in = ST_IDLE;
            end else if (cnt_ff == 7'd127) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (need) depth_in = depth_ff - DW'(1);
            state_in = ST_IDLE;
         end
         ST_RESP: if (rsp_ready) begin
            depth_in = '0; err_in = 1'b0; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Memory port control.
   logic [31:0] result_w;
   always_comb begin
      mem_we = 1'b0;
      mem_wd = result_w;
      mem_addr = AW'(depth_ff - DW'(1));
      unique case (state_ff)
         ST_IDLE: mem_addr = '0;
         ST_READ: begin
            mem_we = is_push && depth_ff < Full;
            mem_wd = push_val;
            mem_addr = is_push ? AW'(depth_ff) : AW'(depth_ff - DW'(1));
         end
         ST_LOAD: mem_addr = AW'(depth_ff - DW'(2));
         ST_WRITE: begin
            mem_we = 1'b1;
            mem_addr = AW'(depth_ff - need_n);
         end
         default: mem_addr = '0;
      endcase
   end

   always_comb begin
      unique case (fn)
         TOK_EQ:   result_w = {31'd0, eq_ff};
         TOK_LT:   result_w = {31'd0, lt_ff};
         TOK_GT:   result_w = {31'd0, ~lt_ff & ~eq_ff};
         TOK_LE:   result_w = {31'd0, lt_ff | eq_ff};
         TOK_GE:   result_w = {31'd0, ~lt_ff};
         TOK_LAND: result_w = {31'd0, nl_ff & nr_ff};
         TOK_LOR:  result_w = {31'd0, nl_ff | nr_ff};
         TOK_LNOT: result_w = {31'd0, ~nz_ff};
         TOK_MUL, TOK_DIV: result_w = q_ff;
         default:  result_w = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; depth_ff <= '0; err_ff <= 1'b0;
      end else begin
         state_ff <= state_in; depth_ff <= depth_in; err_ff <= err_in;
      end
   end

   // Serial datapath. Counter runs 0..31 for bit work and 0..32 for shifts;
   // multiply and divide use the same count over their phases, then jump to
   // 127 to finish. The finish cycle at 127 leaves every register alone.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            func_ff <= req_func; opnd_ff <= req_operand;
         end
         ST_READ: rd_cnt_ff <= 1'b1;
         ST_LOAD: begin
            // First cycle: top of stack arrives. Second: the deeper value.
            if (rd_cnt_ff) begin
               r_ff <= rd_ff;
               l_ff <= 32'd0;
               rd_cnt_ff <= 1'b0;
            end else if (is_bin) begin
               l_ff <= rd_ff;
            end
            cnt_ff <= '0; ph_ff <= '0;
            c_ff <= (func_ff != TOK_ADD) && (func_ff != TOK_MUL);
            eq_ff <= 1'b1; nz_ff <= 1'b0; nl_ff <= 1'b0; nr_ff <= 1'b0;
            lt_ff <= 1'b0; acc_ff <= '0; q_ff <= '0;
         end
         ST_SERIAL: if (cnt_ff != 7'd127) begin
            if (func_ff == TOK_MUL) begin
               // Shift-add, lsb of r first; product low word builds in acc and in q, which gives the result.
               if (r_ff[0]) acc_ff <= acc_ff + l_ff;
               if (r_ff[0]) q_ff <= q_ff + l_ff;
               else q_ff <= q_ff;
               l_ff <= l_ff << 1;
               r_ff <= r_ff >> 1;
               cnt_ff <= (cnt_ff == 7'd31) ? 7'd127 : cnt_ff + 7'd1;
            end else if (func_ff == TOK_DIV) begin
               if (ph_ff == 2'd0) begin
                  nl_ff <= l_ff[31]; nr_ff <= r_ff[31];
                  q_ff <= l_ff[31] ? (32'd0 - l_ff) : l_ff;
                  r_ff <= r_ff[31] ? (32'd0 - r_ff) : r_ff;
                  acc_ff <= '0;
                  ph_ff <= 2'd1; cnt_ff <= '0;
               end else if (ph_ff == 2'd1) begin
                  if (!dtrial[32]) begin
                     acc_ff <= dtrial[31:0]; q_ff <= {q_ff[30:0], 1'b1};
                  end else begin
                     acc_ff <= {acc_ff[30:0], q_ff[31]}; q_ff <= {q_ff[30:0], 1'b0};
                  end
                  if (cnt_ff == 7'd31) ph_ff <= 2'd2;
                  cnt_ff <= cnt_ff + 7'd1;
               end else begin
                  if (nl_ff != nr_ff) q_ff <= 32'd0 - q_ff;
                  cnt_ff <= 7'd127;
               end
            end else if (func_ff == TOK_SHL || func_ff == TOK_SHR) begin
               // One position per cycle, for shamt positions.
               if (cnt_ff == 7'd0) acc_ff <= l_ff;
               else if (cnt_ff[4:0] <= shamt && cnt_ff <= 7'd31)
                  acc_ff <= (func_ff == TOK_SHL) ? {acc_ff[30:0], 1'b0}
                                                 : {acc_ff[31], acc_ff[31:1]};
               cnt_ff <= (cnt_ff == 7'd32) ? 7'd127 : cnt_ff + 7'd1;
            end else begin
               // Bit-serial add/subtract/logic, compare and unary work, lsb first.
               logic b;
               unique case (fn)
                  TOK_ADD: b = sum_bit;
                  TOK_AND: b = l_ff[0] & r_ff[0];
                  TOK_OR:  b = l_ff[0] | r_ff[0];
                  TOK_XOR: b = l_ff[0] ^ r_ff[0];
                  default: b = sub_bit;
               endcase
               acc_ff <= {b, acc_ff[31:1]};
               c_ff <= (fn == TOK_ADD) ? sum_c : sub_c;
               if (l_ff[0] != r_ff[0]) begin
                  eq_ff <= 1'b0;
                  lt_ff <= (cnt_ff == 7'd31) ? l_ff[0] : r_ff[0];
               end
               nz_ff <= nz_ff | r_ff[0];
               nl_ff <= nl_ff | l_ff[0];
               nr_ff <= nr_ff | r_ff[0];
               l_ff <= l_ff >> 1;
               r_ff <= r_ff >> 1;
               cnt_ff <= (cnt_ff == 7'd31) ? 7'd127 : cnt_ff + 7'd1;
            end
         end
         ST_WRITE: ;
         default: ;
      endcase
      if (state_ff == ST_IDLE && req_valid && req_func == TOK_END) begin
         fail_ff <= err_ff || depth_ff != DW'(1);
      end
   end

   // Outputs.
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_RESP);
      rsp_failed = fail_ff;
      rsp_result_value = fail_ff ? ErrorValue : rd_ff;
   end

`ifndef SYNTHESIS
   a_depth: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= Full) else $error("stack depth beyond capacity");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> depth_ff == '0 && !err_ff)
      else $error("end token did not clear the stack");
`endif
endmodule
